FILE: hdl/scf_pkg.sv
// ----------------------------------------------------------------------------
// scf_pkg
// Shared types, constants and rounding for the separable clamped filter.
// ----------------------------------------------------------------------------
`default_nettype none

package scf_pkg;

	localparam int PIX_W     = 16;
	localparam int TAP_W     = 16;
	localparam int RES_W     = 24;
	localparam int NUM_TAPS  = 5;
	localparam int FRAC      = 14;
	localparam int ACC_W     = 48;
	localparam int PROD_W    = 41;
	localparam int GEO_W     = 11;
	localparam int RAD_W     = 3;
	localparam int OFF_W     = 4;
	localparam int DIST_W    = 4;
	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;

	localparam int DEF_MAX_RADIUS = 4;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam logic [GEO_W-1:0] RST_WIDTH  = 11'd1024;
	localparam logic [GEO_W-1:0] RST_HEIGHT = 11'd1024;
	localparam logic [RAD_W-1:0] RST_RADIUS = 3'd1;
	localparam logic [TAP_W-1:0] RST_CENTRE = 16'd16384;

	localparam logic signed [ACC_W-1:0] ROUND_BIAS = 48'sd8192;
	localparam logic signed [ACC_W-1:0] SAT_HI     = 48'sd8388607;
	localparam logic signed [ACC_W-1:0] SAT_LO     = -48'sd8388608;

	typedef enum logic [2:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_RADIUS = 3'd2,
		REG_TAP0   = 3'd3,
		REG_TAP1   = 3'd4,
		REG_TAP2   = 3'd5,
		REG_TAP3   = 3'd6,
		REG_TAP4   = 3'd7
	} reg_idx_t;

	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_DRAIN = 1'b1
	} cmd_code_t;

	typedef struct packed {
		logic             command;
		logic [PIX_W-1:0] pixel;
	} in_item_t;

	typedef struct packed {
		logic signed [RES_W-1:0] filtered;
		logic                    frame_end;
	} out_item_t;

	typedef struct packed {
		logic [GEO_W-1:0]                width;
		logic [GEO_W-1:0]                height;
		logic [RAD_W-1:0]                radius;
		logic [NUM_TAPS-1:0][TAP_W-1:0]  taps;
	} cfg_t;

	typedef struct packed {
		logic             win_shift;
		logic             acc_clear;
		logic             h_issue;
		logic             v_issue;
		logic [OFF_W-1:0] off;
		logic [RAD_W-1:0] tsel;
		logic             ram_we;
		logic             res_load;
		logic             res_last;
	} dp_cmd_t;

	typedef struct packed {
		logic res_busy;
	} dp_stat_t;

	// round half up, shift right FRAC with floor, saturate to RES_W bits
	function automatic logic signed [RES_W-1:0] round_sat(input logic signed [ACC_W-1:0] s);
		logic signed [ACC_W-1:0] v;
		logic signed [ACC_W-1:0] q;
		v = s + ROUND_BIAS;
		q = v >>> FRAC;
		if (q > SAT_HI) begin
			q = SAT_HI;
		end else if (q < SAT_LO) begin
			q = SAT_LO;
		end
		return q[RES_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: hdl/scf_ram.sv
// ----------------------------------------------------------------------------
// scf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 9216
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: hdl/scf_dp.sv
// ----------------------------------------------------------------------------
// scf_dp
// Datapath: pixel window, shared MAC, row store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scf_dp #(
	parameter int MAX_RADIUS = scf_pkg::DEF_MAX_RADIUS,
	parameter int MAX_WIDTH  = scf_pkg::DEF_MAX_WIDTH,
	localparam int WIN  = 2 * MAX_RADIUS + 1,
	localparam int AW   = $clog2(WIN * MAX_WIDTH)
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire scf_pkg::dp_cmd_t                              cmd,
	input  wire logic [AW-1:0]                                 addr,
	input  wire logic [scf_pkg::PIX_W-1:0]                     pixel,
	input  wire logic [scf_pkg::NUM_TAPS-1:0][scf_pkg::TAP_W-1:0] taps,
	output scf_pkg::dp_stat_t                                  stat,
	output logic                                               res_valid,
	input  wire logic                                          res_stall,
	output scf_pkg::out_item_t                                 res_data
);

	localparam int OB = (WIN > 1) ? $clog2(WIN) : 1;

	logic [scf_pkg::PIX_W-1:0]               win_q [WIN];
	logic [scf_pkg::PIX_W-1:0]               sample_s1;
	logic signed [scf_pkg::TAP_W-1:0]        tap_s1;
	logic                                    src_s1;
	logic                                    vld_s1;
	logic signed [scf_pkg::PROD_W-1:0]       prod_s2;
	logic                                    vld_s2;
	logic signed [scf_pkg::ACC_W-1:0]        acc_q;
	logic [scf_pkg::RES_W-1:0]               rdata;
	logic signed [scf_pkg::RES_W:0]          oper;
	logic signed [scf_pkg::RES_W-1:0]        rnd;
	logic [scf_pkg::TAP_W-1:0]               tap_pick;
	logic                                    res_valid_q;
	scf_pkg::out_item_t                      res_data_q;

	always_comb begin
		case (cmd.tsel)
			3'd0:    tap_pick = taps[0];
			3'd1:    tap_pick = taps[1];
			3'd2:    tap_pick = taps[2];
			3'd3:    tap_pick = taps[3];
			3'd4:    tap_pick = taps[4];
			default: tap_pick = '0;
		endcase
	end

	// window: entry 0 is the newest pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd.win_shift) begin
			win_q[0] <= pixel;
			for (int i = 1; i < WIN; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end
	end

	// operand stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.h_issue | cmd.v_issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		sample_s1 <= win_q[cmd.off[OB-1:0]];
		tap_s1    <= $signed(tap_pick);
		src_s1    <= cmd.v_issue;
	end

	assign oper = src_s1 ? $signed({rdata[scf_pkg::RES_W-1], rdata})
	                     : $signed({{(scf_pkg::RES_W + 1 - scf_pkg::PIX_W){1'b0}}, sample_s1});

	// multiply stage
	always_ff @(posedge clk) begin
		prod_s2 <= tap_s1 * oper;
	end

	// accumulate
	always_ff @(posedge clk) begin
		if (cmd.acc_clear) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + scf_pkg::ACC_W'(prod_s2);
		end
	end

	assign rnd = scf_pkg::round_sat(acc_q);

	scf_ram #(
		.WIDTH (scf_pkg::RES_W),
		.DEPTH (WIN * MAX_WIDTH)
	) u_row_store (
		.clk   (clk),
		.we    (cmd.ram_we),
		.waddr (addr),
		.wdata (rnd),
		.raddr (addr),
		.rdata (rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_data_q.filtered  <= rnd;
			res_data_q.frame_end <= cmd.res_last;
		end
	end

	assign res_valid     = res_valid_q;
	assign res_data      = res_data_q;
	assign stat.res_busy = res_valid_q & res_stall;

endmodule

`default_nettype wire

FILE: hdl/scf_ctrl.sv
// ----------------------------------------------------------------------------
// scf_ctrl
// Controller: frame positions, tap sequencing and row store addressing.
// ----------------------------------------------------------------------------
`default_nettype none

module scf_ctrl #(
	parameter int MAX_RADIUS = scf_pkg::DEF_MAX_RADIUS,
	parameter int MAX_WIDTH  = scf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = scf_pkg::DEF_MAX_HEIGHT,
	localparam int ROWS = 2 * MAX_RADIUS + 1,
	localparam int AW   = $clog2(ROWS * MAX_WIDTH)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire scf_pkg::cfg_t      cfg,
	input  wire logic               cfg_wr,
	input  wire logic               pix_valid,
	output logic                    pix_stall,
	input  wire logic               pix_cmd,
	input  wire scf_pkg::dp_stat_t  stat,
	output scf_pkg::dp_cmd_t        cmd,
	output logic [AW-1:0]           addr
);

	localparam int CB      = $clog2(MAX_WIDTH);
	localparam int WB      = $clog2(MAX_WIDTH + 1);
	localparam int RB      = $clog2(MAX_HEIGHT + 1);
	localparam int SB      = $clog2(ROWS);
	localparam int LAT_MAX = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS;
	localparam int PB      = $clog2(LAT_MAX + 2);
	localparam int CS      = CB + 3;
	localparam int RS      = RB + 3;
	localparam int SS      = SB + 3;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_H_MAC = 10'b0000000010,
		S_H_W1  = 10'b0000000100,
		S_H_W2  = 10'b0000001000,
		S_H_WR  = 10'b0000010000,
		S_POST  = 10'b0000100000,
		S_V_MAC = 10'b0001000000,
		S_V_W1  = 10'b0010000000,
		S_V_W2  = 10'b0100000000,
		S_V_OUT = 10'b1000000000
	} state_t;

	state_t                           state_q, state_d;
	logic [CB-1:0]                    in_col_q, out_col_q, x_q, c_q, cend_q;
	logic [RB-1:0]                    in_row_q, out_row_q;
	logic [SB-1:0]                    in_slot_q, out_slot_q;
	logic [PB-1:0]                    pend_q, lat;
	logic signed [scf_pkg::DIST_W-1:0] d_q, rad_s;

	logic [WB-1:0]                    w;
	logic [RB-1:0]                    h;
	logic [scf_pkg::RAD_W-1:0]        r;
	logic [CB-1:0]                    wm1;
	logic [RB-1:0]                    hm1;
	logic                             take, in_done, last;
	logic signed [CS-1:0]             cd, cidx;
	logic signed [RS-1:0]             rd;
	logic signed [scf_pkg::DIST_W-1:0] delta;
	logic signed [SS-1:0]             slot_s;
	logic [SB-1:0]                    slot;
	logic [scf_pkg::RAD_W-1:0]        absd;

	// effective geometry
	always_comb begin
		if (cfg.width == '0) begin
			w = WB'(1);
		end else if (32'(cfg.width) > MAX_WIDTH) begin
			w = WB'(MAX_WIDTH);
		end else begin
			w = WB'(cfg.width);
		end
		if (cfg.height == '0) begin
			h = RB'(1);
		end else if (32'(cfg.height) > MAX_HEIGHT) begin
			h = RB'(MAX_HEIGHT);
		end else begin
			h = RB'(cfg.height);
		end
		if (cfg.radius == '0) begin
			r = scf_pkg::RAD_W'(1);
		end else if (32'(cfg.radius) > MAX_RADIUS) begin
			r = scf_pkg::RAD_W'(MAX_RADIUS);
		end else begin
			r = cfg.radius;
		end
	end

	assign wm1     = CB'(w - WB'(1));
	assign hm1     = h - RB'(1);
	assign lat     = PB'(32'(r) * 32'(w) + 32'(r));
	assign rad_s   = $signed({1'b0, r});
	assign in_done = (in_row_q >= h);
	assign last    = (out_row_q == hm1) && (out_col_q == wm1);
	assign take    = pix_valid && !pix_stall;
	assign absd    = scf_pkg::RAD_W'((d_q < 0) ? -d_q : d_q);

	// horizontal neighbor, clamped to the row
	always_comb begin
		cd = $signed({3'b000, c_q}) + CS'(d_q);
		if (cd < 0) begin
			cidx = '0;
		end else if (cd > $signed({3'b000, wm1})) begin
			cidx = $signed({3'b000, wm1});
		end else begin
			cidx = cd;
		end
	end

	// vertical neighbor, clamped to the frame, mapped to its ring slot
	always_comb begin
		rd = $signed({3'b000, out_row_q}) + RS'(d_q);
		if (rd < 0) begin
			rd = '0;
		end else if (rd > $signed({3'b000, hm1})) begin
			rd = $signed({3'b000, hm1});
		end
		delta  = scf_pkg::DIST_W'(rd - $signed({3'b000, out_row_q}));
		slot_s = $signed({3'b000, out_slot_q}) + SS'(delta);
		if (slot_s < 0) begin
			slot_s = slot_s + SS'(ROWS);
		end else if (slot_s >= SS'(ROWS)) begin
			slot_s = slot_s - SS'(ROWS);
		end
		slot = slot_s[SB-1:0];
	end

	always_comb begin
		cmd       = '0;
		addr      = AW'(in_slot_q) * AW'(MAX_WIDTH) + AW'(c_q);
		pix_stall = (state_q != S_IDLE);
		state_d   = state_q;
		cmd.tsel  = absd;
		cmd.off   = scf_pkg::OFF_W'(x_q - cidx[CB-1:0]);
		case (state_q)
			S_IDLE: begin
				if (take) begin
					if (pix_cmd == scf_pkg::CMD_DRAIN) begin
						if (in_done && (out_row_q < h)) begin
							state_d = S_V_MAC;
						end
					end else if (!in_done) begin
						cmd.win_shift = 1'b1;
						if ((in_col_q == wm1) || (in_col_q >= CB'(r))) begin
							state_d = S_H_MAC;
						end else begin
							state_d = S_POST;
						end
					end
				end
			end
			S_H_MAC: begin
				cmd.h_issue   = 1'b1;
				cmd.acc_clear = (d_q == -rad_s);
				if (d_q == rad_s) begin
					state_d = S_H_W1;
				end
			end
			S_H_W1: state_d = S_H_W2;
			S_H_W2: state_d = S_H_WR;
			S_H_WR: begin
				cmd.ram_we = 1'b1;
				state_d    = (c_q == cend_q) ? S_POST : S_H_MAC;
			end
			S_POST: begin
				state_d = (pend_q >= lat) ? S_V_MAC : S_IDLE;
			end
			S_V_MAC: begin
				addr          = AW'(slot) * AW'(MAX_WIDTH) + AW'(out_col_q);
				cmd.v_issue   = 1'b1;
				cmd.acc_clear = (d_q == -rad_s);
				if (d_q == rad_s) begin
					state_d = S_V_W1;
				end
			end
			S_V_W1: state_d = S_V_W2;
			S_V_W2: state_d = S_V_OUT;
			S_V_OUT: begin
				if (!stat.res_busy) begin
					cmd.res_load = 1'b1;
					cmd.res_last = last;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			pend_q     <= '0;
			x_q        <= '0;
			c_q        <= '0;
			cend_q     <= '0;
			d_q        <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				in_col_q   <= '0;
				in_row_q   <= '0;
				in_slot_q  <= '0;
				out_col_q  <= '0;
				out_row_q  <= '0;
				out_slot_q <= '0;
				pend_q     <= '0;
			end
			case (state_q)
				S_IDLE: begin
					d_q    <= -rad_s;
					x_q    <= in_col_q;
					cend_q <= (in_col_q == wm1) ? in_col_q : in_col_q - CB'(r);
					c_q    <= (in_col_q >= CB'(r)) ? in_col_q - CB'(r) : '0;
				end
				S_H_MAC, S_V_MAC: begin
					if (d_q != rad_s) begin
						d_q <= d_q + scf_pkg::DIST_W'(1);
					end
				end
				S_H_WR: begin
					c_q <= c_q + CB'(1);
					d_q <= -rad_s;
				end
				S_POST: begin
					pend_q <= pend_q + PB'(1);
					d_q    <= -rad_s;
					if (in_col_q == wm1) begin
						in_col_q  <= '0;
						in_row_q  <= in_row_q + RB'(1);
						in_slot_q <= (in_slot_q == SB'(ROWS - 1)) ? '0 : in_slot_q + SB'(1);
					end else begin
						in_col_q <= in_col_q + CB'(1);
					end
				end
				S_V_OUT: begin
					if (!stat.res_busy) begin
						if (last) begin
							in_col_q   <= '0;
							in_row_q   <= '0;
							in_slot_q  <= '0;
							out_col_q  <= '0;
							out_row_q  <= '0;
							out_slot_q <= '0;
							pend_q     <= '0;
						end else begin
							pend_q <= pend_q - PB'(1);
							if (out_col_q == wm1) begin
								out_col_q  <= '0;
								out_row_q  <= out_row_q + RB'(1);
								out_slot_q <= (out_slot_q == SB'(ROWS - 1)) ? '0
								              : out_slot_q + SB'(1);
							end else begin
								out_col_q <= out_col_q + CB'(1);
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// input column always inside the row
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (WB'(in_col_q) < w))
		else $error("input column beyond row width");

	// results never run ahead of the required latency window
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (pend_q <= lat))
		else $error("pending count above latency");

	// last result of a frame restarts every position
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.res_load && cmd.res_last && !cfg_wr) |=>
		(in_row_q == '0 && out_row_q == '0 && pend_q == '0))
		else $error("frame end did not clear positions");

	// the row store is written only between rows of a horizontal pass
	a_wr_only_h: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ram_we |-> $past(state_q == S_H_W2))
		else $error("row store write outside horizontal pass");

endmodule

`default_nettype wire

FILE: hdl/separable_convolution_clamped_top.sv
// ----------------------------------------------------------------------------
// separable_convolution_clamped_top
// Separable 2-D filter with clamp-to-edge borders and APB configuration.
// ----------------------------------------------------------------------------
// Raster-order pixels come in on the pix channel; each request is a pixel or
// a drain. A horizontal pass (taps Q2.14, round, >>14, saturate to 24 bits)
// writes row results into a ring of 2*MAX_RADIUS+1 rows held in one RAM, and
// a vertical pass over that ring gives the output, which follows its input
// by R*W+R pixels. After the last pixel, drain requests push out the rest;
// frame_end marks the last result, after which a new frame starts. Any
// register write drops the frame in progress. Requests are taken one at a
// time through a single shared multiply-accumulate: a pixel runs one tap walk
// per row result it makes (none in the first R columns, one after, up to R+1
// at a row end), plus one when it yields a result; a drain runs at most one.
// A result waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module separable_convolution_clamped_top #(
	parameter int MAX_RADIUS = scf_pkg::DEF_MAX_RADIUS,
	parameter int MAX_WIDTH  = scf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = scf_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// pixel / drain requests
	input  wire logic                          pix_valid,
	output logic                               pix_stall,
	input  wire scf_pkg::in_item_t             pix_data,
	// filtered results
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output scf_pkg::out_item_t                 res_data,
	// configuration
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [scf_pkg::APB_AW-1:0]    paddr,
	input  wire logic [scf_pkg::APB_DW-1:0]    pwdata,
	output logic [scf_pkg::APB_DW-1:0]         prdata,
	output logic                               pready
);

	localparam int ROWS = 2 * MAX_RADIUS + 1;
	localparam int AW   = $clog2(ROWS * MAX_WIDTH);

	scf_pkg::cfg_t      cfg_q;
	scf_pkg::reg_idx_t  idx;
	scf_pkg::dp_cmd_t   cmd;
	scf_pkg::dp_stat_t  stat;
	logic               cfg_wr;
	logic [AW-1:0]      addr;

	assign pready = 1'b1;
	assign idx    = scf_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg_wr = psel && penable && pwrite && pready;

	// register file; all eight word addresses map to a register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width   <= scf_pkg::RST_WIDTH;
			cfg_q.height  <= scf_pkg::RST_HEIGHT;
			cfg_q.radius  <= scf_pkg::RST_RADIUS;
			cfg_q.taps    <= '0;
			cfg_q.taps[0] <= scf_pkg::RST_CENTRE;
		end else if (cfg_wr) begin
			case (idx)
				scf_pkg::REG_WIDTH:  cfg_q.width   <= pwdata[scf_pkg::GEO_W-1:0];
				scf_pkg::REG_HEIGHT: cfg_q.height  <= pwdata[scf_pkg::GEO_W-1:0];
				scf_pkg::REG_RADIUS: cfg_q.radius  <= pwdata[scf_pkg::RAD_W-1:0];
				scf_pkg::REG_TAP0:   cfg_q.taps[0] <= pwdata[scf_pkg::TAP_W-1:0];
				scf_pkg::REG_TAP1:   cfg_q.taps[1] <= pwdata[scf_pkg::TAP_W-1:0];
				scf_pkg::REG_TAP2:   cfg_q.taps[2] <= pwdata[scf_pkg::TAP_W-1:0];
				scf_pkg::REG_TAP3:   cfg_q.taps[3] <= pwdata[scf_pkg::TAP_W-1:0];
				scf_pkg::REG_TAP4:   cfg_q.taps[4] <= pwdata[scf_pkg::TAP_W-1:0];
				default: ;
			endcase
		end
	end

	// read back, zero extended
	always_comb begin
		case (idx)
			scf_pkg::REG_WIDTH:  prdata = scf_pkg::APB_DW'(cfg_q.width);
			scf_pkg::REG_HEIGHT: prdata = scf_pkg::APB_DW'(cfg_q.height);
			scf_pkg::REG_RADIUS: prdata = scf_pkg::APB_DW'(cfg_q.radius);
			scf_pkg::REG_TAP0:   prdata = scf_pkg::APB_DW'(cfg_q.taps[0]);
			scf_pkg::REG_TAP1:   prdata = scf_pkg::APB_DW'(cfg_q.taps[1]);
			scf_pkg::REG_TAP2:   prdata = scf_pkg::APB_DW'(cfg_q.taps[2]);
			scf_pkg::REG_TAP3:   prdata = scf_pkg::APB_DW'(cfg_q.taps[3]);
			scf_pkg::REG_TAP4:   prdata = scf_pkg::APB_DW'(cfg_q.taps[4]);
			default:             prdata = '0;
		endcase
	end

	// sequencing: positions, tap walk, row store addresses
	scf_ctrl #(
		.MAX_RADIUS (MAX_RADIUS),
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cfg_wr    (cfg_wr),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_cmd   (pix_data.command),
		.stat      (stat),
		.cmd       (cmd),
		.addr      (addr)
	);

	// window, MAC, row store, output register
	scf_dp #(
		.MAX_RADIUS (MAX_RADIUS),
		.MAX_WIDTH  (MAX_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.addr      (addr),
		.pixel     (pix_data.pixel),
		.taps      (cfg_q.taps),
		.stat      (stat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

`default_nettype wire
